/* rtl/mcw_pkg.sv */
package mcw_pkg;

	localparam int TEXT_MAX    = 4096;
	localparam int PATTERN_MAX = 4096;
	localparam int ALPHABET    = 256;

	localparam int SYM_W   = 8;
	localparam int SYM_AW  = $clog2(ALPHABET);
	localparam int TEXT_AW = $clog2(TEXT_MAX);
	localparam int LEN_W   = TEXT_AW + 1;
	localparam int PLEN_W  = $clog2(PATTERN_MAX) + 1;
	localparam int CNT_W   = $clog2(PATTERN_MAX) + 2;
	localparam int UNMET_W = SYM_AW + 1;

	localparam logic CMD_PATTERN = 1'b0;
	localparam logic CMD_TEXT    = 1'b1;

	typedef struct packed {
		logic             cmd;
		logic [SYM_W-1:0] symbol;
		logic             last;
	} item_t;

	typedef struct packed {
		logic               found;
		logic [TEXT_AW-1:0] start_res;
		logic [LEN_W-1:0]   length;
		logic               overflow;
	} result_t;

	typedef struct packed {
		logic             in_pattern;
		logic [CNT_W-1:0] need;
	} cnt_entry_t;

endpackage

/* rtl/min_covering_window.sv */
// Finds the shortest window of a text stream that contains every pattern byte as often as
// the pattern does. Send the pattern bytes first (cmd 0), then the text bytes (cmd 1); the
// text byte with last set ends the job, produces one result transfer and clears the tables
// for the next job. Up to 4096 pattern bytes and 4096 text bytes are kept per job; extra
// bytes are dropped and flag overflow. Ties go to the earliest window, and an empty
// pattern reports found with length 0. A pattern byte passes through ST_PWR. A text byte
// passes through ST_TWR and ST_CHK, then ST_TXT, ST_CNT and ST_CHK again for each byte
// the window releases from its left edge, and each byte is released at most once. A
// text byte that arrives while the pattern is empty, or that is dropped, skips these
// states. The last byte then passes through ST_OUT, which loads the result and waits
// there while an earlier result transfer is still stalled. This sequence comes from the
// read-modify-write of the need-count memory and the registered read of the text buffer.
module min_covering_window import mcw_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PWR  = 3'd1;
	localparam logic [2:0] ST_TWR  = 3'd2;
	localparam logic [2:0] ST_CHK  = 3'd3;
	localparam logic [2:0] ST_TXT  = 3'd4;
	localparam logic [2:0] ST_CNT  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0]          state_q;
	logic                last_q;
	logic                ovf_q;
	logic [UNMET_W-1:0]  unmet_q;
	logic [LEN_W-1:0]    left_q;
	logic [LEN_W-1:0]    right_q;
	logic [PLEN_W-1:0]   plen_q;
	logic                best_valid_q;
	logic [LEN_W-1:0]    best_len_q;
	logic [TEXT_AW-1:0]  best_start_q;
	logic [ALPHABET-1:0] vld_q;
	logic                result_valid_q;
	result_t             result_q;

	cnt_entry_t         cnt_mem [ALPHABET];
	cnt_entry_t         cnt_rdata;
	cnt_entry_t         cnt_wdata;
	logic               cnt_we;
	logic [SYM_AW-1:0]  cnt_raddr;
	logic [SYM_AW-1:0]  cnt_addr_q;
	logic               cnt_load;

	logic [SYM_W-1:0]   txt_mem [TEXT_MAX];
	logic [SYM_W-1:0]   txt_rdata;
	logic               txt_we;

	logic               accept;
	logic               plen_full;
	logic               text_full;
	logic               cur_inp;
	logic [CNT_W-1:0]   cur_cnt;
	logic [CNT_W-1:0]   cnt_inc;
	logic [CNT_W-1:0]   cnt_dec;
	logic [LEN_W-1:0]   width;
	logic               shrink;
	logic               out_free;

	assign item_stall   = (state_q != ST_IDLE);
	assign accept       = item_valid && !item_stall;
	assign plen_full    = (plen_q >= PLEN_W'(PATTERN_MAX));
	assign text_full    = (right_q >= LEN_W'(TEXT_MAX));
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign out_free     = !result_valid_q || !result_stall;

	assign cur_inp = vld_q[cnt_addr_q] ? cnt_rdata.in_pattern : 1'b0;
	assign cur_cnt = vld_q[cnt_addr_q] ? cnt_rdata.need : '0;
	assign cnt_inc = cur_cnt + CNT_W'(1);
	assign cnt_dec = cur_cnt - CNT_W'(1);
	assign width   = right_q - left_q;
	assign shrink  = (unmet_q == '0) && (left_q < right_q);

	assign txt_we = accept && (item.cmd == CMD_TEXT) && !text_full;

	always_comb begin
		cnt_raddr = item.symbol[SYM_AW-1:0];
		cnt_load  = 1'b0;
		if (state_q == ST_IDLE) begin
			cnt_raddr = item.symbol[SYM_AW-1:0];
			cnt_load  = accept;
		end else if (state_q == ST_TXT) begin
			cnt_raddr = txt_rdata[SYM_AW-1:0];
			cnt_load  = 1'b1;
		end
	end

	always_comb begin
		cnt_we    = 1'b0;
		cnt_wdata = '{in_pattern: 1'b1, need: cnt_inc};
		case (state_q)
			ST_PWR: begin
				cnt_we = 1'b1;
			end
			ST_TWR: begin
				cnt_we    = cur_inp;
				cnt_wdata = '{in_pattern: 1'b1, need: cnt_dec};
			end
			ST_CNT: begin
				cnt_we = cur_inp;
			end
			default: begin
				cnt_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_addr_q] <= cnt_wdata;
		end
		cnt_rdata <= cnt_mem[cnt_raddr];
		if (cnt_load) begin
			cnt_addr_q <= cnt_raddr;
		end
	end

	always_ff @(posedge clk) begin
		if (txt_we) begin
			txt_mem[right_q[TEXT_AW-1:0]] <= item.symbol;
		end
		txt_rdata <= txt_mem[left_q[TEXT_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			last_q         <= 1'b0;
			ovf_q          <= 1'b0;
			unmet_q        <= '0;
			left_q         <= '0;
			right_q        <= '0;
			plen_q         <= '0;
			best_valid_q   <= 1'b0;
			best_len_q     <= '0;
			best_start_q   <= '0;
			vld_q          <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (result_valid_q && !result_stall && (state_q != ST_OUT)) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (item.cmd == CMD_PATTERN) begin
							if (plen_full) begin
								ovf_q <= 1'b1;
							end else begin
								state_q <= ST_PWR;
							end
						end else begin
							last_q <= item.last;
							if (text_full) begin
								ovf_q   <= 1'b1;
								state_q <= item.last ? ST_OUT : ST_IDLE;
							end else begin
								right_q <= right_q + LEN_W'(1);
								if (plen_q == '0) begin
									state_q <= item.last ? ST_OUT : ST_IDLE;
								end else begin
									state_q <= ST_TWR;
								end
							end
						end
					end
				end
				ST_PWR: begin
					plen_q             <= plen_q + PLEN_W'(1);
					vld_q[cnt_addr_q]  <= 1'b1;
					if (!cur_inp) begin
						unmet_q <= unmet_q + UNMET_W'(1);
					end
					state_q <= ST_IDLE;
				end
				ST_TWR: begin
					if (cur_inp) begin
						vld_q[cnt_addr_q] <= 1'b1;
						if (cnt_dec == '0) begin
							unmet_q <= unmet_q - UNMET_W'(1);
						end
					end
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (shrink) begin
						if (!best_valid_q || (width < best_len_q)) begin
							best_valid_q <= 1'b1;
							best_len_q   <= width;
							best_start_q <= left_q[TEXT_AW-1:0];
						end
						state_q <= ST_TXT;
					end else begin
						state_q <= last_q ? ST_OUT : ST_IDLE;
					end
				end
				ST_TXT: begin
					state_q <= ST_CNT;
				end
				ST_CNT: begin
					if (cur_inp) begin
						vld_q[cnt_addr_q] <= 1'b1;
						if (!cnt_inc[CNT_W-1] && (cnt_inc != '0)) begin
							unmet_q <= unmet_q + UNMET_W'(1);
						end
					end
					left_q  <= left_q + LEN_W'(1);
					state_q <= ST_CHK;
				end
				ST_OUT: begin
					if (out_free) begin
						result_valid_q     <= 1'b1;
						result_q.overflow  <= ovf_q;
						if (plen_q == '0) begin
							result_q.found     <= 1'b1;
							result_q.start_res <= '0;
							result_q.length    <= '0;
						end else if (best_valid_q) begin
							result_q.found     <= 1'b1;
							result_q.start_res <= best_start_q;
							result_q.length    <= best_len_q;
						end else begin
							result_q.found     <= 1'b0;
							result_q.start_res <= '0;
							result_q.length    <= '0;
						end
						last_q       <= 1'b0;
						ovf_q        <= 1'b0;
						unmet_q      <= '0;
						left_q       <= '0;
						right_q      <= '0;
						plen_q       <= '0;
						best_valid_q <= 1'b0;
						best_len_q   <= '0;
						best_start_q <= '0;
						vld_q        <= '0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_left_le_right: assert property (@(posedge clk) disable iff (!arst_n)
		left_q <= right_q)
		else $error("Window left edge passed the right edge.");

	a_text_bound: assert property (@(posedge clk) disable iff (!arst_n)
		right_q <= LEN_W'(TEXT_MAX))
		else $error("Text count exceeded the buffer capacity.");

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=>
			(right_q == '0 && plen_q == '0 && vld_q == '0 && result_valid_q))
		else $error("Job state was not cleared when the result was loaded.");

	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && !result_q.found) |-> (result_q.length == '0))
		else $error("A result without a window carries a nonzero length.");
`endif

endmodule

/* bench/min_covering_window_test.sv */
`timescale 1ns / 1ps

module min_covering_window_test;
	import mcw_pkg::*;

	typedef struct packed {
		item_t   it;
		logic    typed;
		result_t want;
	} stim_row_t;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	min_covering_window dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	// Window search state of the predictor.
	int         need [ALPHABET];
	bit         member [ALPHABET];
	int         unmet;
	logic [7:0] text_buf [TEXT_MAX];
	int         win_left;
	int         win_right;
	int         pat_len;
	int         best_len;
	bit         best_ok;
	int         best_st;
	bit         lost_bytes;

	result_t expected_results [$];
	int      items_sent;
	int      results_checked;
	int      mismatch_count;
	int      burst_left;
	int      stall_mode;
	int      stall_phase;

	stim_row_t directed_rows [17] = '{
		'{'{CMD_TEXT,    8'h61, 1'b1}, 1'b1, '{1'b1, 12'd0, 13'd0, 1'b0}},
		'{'{CMD_PATTERN, 8'h00, 1'b0}, 1'b0, '0},
		'{'{CMD_PATTERN, 8'hFF, 1'b0}, 1'b0, '0},
		'{'{CMD_TEXT,    8'h00, 1'b0}, 1'b0, '0},
		'{'{CMD_TEXT,    8'h11, 1'b0}, 1'b0, '0},
		'{'{CMD_TEXT,    8'hFF, 1'b0}, 1'b0, '0},
		'{'{CMD_TEXT,    8'h00, 1'b0}, 1'b0, '0},
		'{'{CMD_TEXT,    8'hFF, 1'b1}, 1'b0, '0},
		'{'{CMD_PATTERN, 8'h41, 1'b0}, 1'b0, '0},
		'{'{CMD_PATTERN, 8'h41, 1'b0}, 1'b0, '0},
		'{'{CMD_TEXT,    8'h41, 1'b1}, 1'b1, '{1'b0, 12'd0, 13'd0, 1'b0}},
		'{'{CMD_PATTERN, 8'h7E, 1'b1}, 1'b0, '0},
		'{'{CMD_TEXT,    8'h7E, 1'b1}, 1'b1, '{1'b1, 12'd0, 13'd1, 1'b0}},
		'{'{CMD_TEXT,    8'h10, 1'b0}, 1'b0, '0},
		'{'{CMD_PATTERN, 8'h10, 1'b0}, 1'b0, '0},
		'{'{CMD_TEXT,    8'h20, 1'b0}, 1'b0, '0},
		'{'{CMD_TEXT,    8'h10, 1'b1}, 1'b0, '0}
	};

	task automatic clear_job();
		for (int i = 0; i < ALPHABET; i++) begin
			need[i] = 0;
			member[i] = 0;
		end
		unmet = 0;
		win_left = 0;
		win_right = 0;
		pat_len = 0;
		best_len = 0;
		best_ok = 0;
		best_st = 0;
		lost_bytes = 0;
	endtask

	task automatic covering_window_step(input item_t it, output bit emits, output result_t res);
		int s;
		int w;
		int t;
		s = int'(it.symbol);
		emits = 0;
		res = '0;
		if (it.cmd == CMD_PATTERN) begin
			if (pat_len >= PATTERN_MAX) begin
				lost_bytes = 1;
			end else begin
				pat_len++;
				need[s]++;
				if (!member[s]) begin
					member[s] = 1;
					unmet++;
				end
			end
			return;
		end
		if (win_right >= TEXT_MAX) begin
			lost_bytes = 1;
		end else begin
			text_buf[win_right] = it.symbol;
			win_right++;
			if (pat_len != 0) begin
				if (member[s]) begin
					need[s]--;
					if (need[s] == 0)
						unmet--;
				end
				while (unmet == 0 && win_left < win_right) begin
					w = win_right - win_left;
					if (!best_ok || w < best_len) begin
						best_ok = 1;
						best_len = w;
						best_st = win_left;
					end
					t = int'(text_buf[win_left]);
					if (member[t]) begin
						need[t]++;
						if (need[t] > 0)
							unmet++;
					end
					win_left++;
				end
			end
		end
		if (!it.last)
			return;
		emits = 1;
		res.overflow = lost_bytes;
		if (pat_len == 0) begin
			res.found = 1'b1;
		end else if (best_ok) begin
			res.found = 1'b1;
			res.start_res = best_st[TEXT_AW-1:0];
			res.length = best_len[LEN_W-1:0];
		end
		clear_job();
	endtask

	// Called just after a falling edge; returns just after the falling edge that follows
	// the transfer.
	task automatic push_item(input item_t it, input bit typed, input result_t want);
		bit      emits;
		result_t res;
		if (burst_left == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
			                                          : $urandom_range(1, 16);
		end
		burst_left--;
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		items_sent++;
		covering_window_step(it, emits, res);
		if (emits)
			expected_results.push_back(typed ? want : res);
		@(negedge clk);
	endtask

	task automatic push_plain(input logic cmd, input logic [7:0] sym, input logic last);
		push_item('{cmd, sym, last}, 1'b0, '0);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("min_covering_window verification failed");
		$finish;
	end

	always @(negedge clk) begin
		if (stall_phase == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_phase = $urandom_range(20, 120);
		end
		stall_phase--;
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 3) == 0);
			default: result_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$error("result transfer with no expected result pending");
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (result.found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, result.found);
					mismatch_count++;
				end
				if (result.start_res !== want.start_res) begin
					$error("start_res: expected %0d, got %0d", want.start_res,
					       result.start_res);
					mismatch_count++;
				end
				if (result.length !== want.length) begin
					$error("length: expected %0d, got %0d", want.length, result.length);
					mismatch_count++;
				end
				if (result.overflow !== want.overflow) begin
					$error("overflow: expected %0d, got %0d", want.overflow,
					       result.overflow);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		logic [7:0] alpha [4];
		int         k;
		int         plen;
		int         tlen;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		stall_mode = 0;
		stall_phase = 0;
		burst_left = 0;
		items_sent = 0;
		results_checked = 0;
		mismatch_count = 0;
		clear_job();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			push_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);

		while (items_sent < 550) begin
			if ($urandom_range(0, 11) == 0) begin
				repeat ($urandom_range(1, 10))
					push_plain(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
					           1'($urandom_range(0, 1)));
				push_plain(CMD_TEXT, 8'($urandom_range(0, 255)), 1'b1);
			end else begin
				k = $urandom_range(1, 4);
				for (int i = 0; i < 4; i++)
					alpha[i] = 8'($urandom_range(0, 255));
				plen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
				repeat (plen)
					push_plain(CMD_PATTERN, alpha[$urandom_range(0, k - 1)],
					           $urandom_range(0, 7) == 0);
				tlen = $urandom_range(1, 40);
				for (int i = 0; i < tlen; i++) begin
					if ($urandom_range(0, 19) == 0)
						push_plain(CMD_PATTERN, alpha[$urandom_range(0, k - 1)], 1'b0);
					push_plain(CMD_TEXT, ($urandom_range(0, 3) == 0) ?
					           8'($urandom_range(0, 255)) : alpha[$urandom_range(0, k - 1)],
					           i == tlen - 1);
				end
			end
		end
		item_valid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		$display("Sent %0d item transfers and compared %0d results over directed and random",
		         items_sent, results_checked);
		$display("jobs, with bursty input and a stalling result receiver.");
		if (mismatch_count == 0) begin
			$display("min_covering_window verification clean");
		end else begin
			$display("min_covering_window verification failed");
		end
		$finish;
	end

endmodule
